### design/hsrl_pkg.sv
// shared types and constants of the hashed source rate limiter
// no dependencies; imported by every module of the block but hsrl_ram
package hsrl_pkg;

  // djb2 seed and shift (h * 33 = (h << 5) + h)
  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int unsigned HASH_SHIFT = 5;

  // bytes folded into the hash per cycle
  localparam int unsigned BYTES_PER_STEP = 4;

  // key and timestamp widths set by the request fields
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SLOT_O_W = 6;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 16'd1000;
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = 16'hFFFF;

  // parameter defaults
  localparam int unsigned DEF_NUM_SLOTS = 64;
  localparam int unsigned DEF_KEY_BYTES = 16;

  // one bucket as stored in the table memory
  typedef struct packed {
    logic               valid;
    logic [HASH_W-1:0]  hash;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  start_ms;
  } bucket_t;

endpackage

### design/hsrl_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module hsrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/hsrl_hash.sv
// iterative djb2 hash over the source key, four bytes per cycle
// depends on hsrl_pkg
module hsrl_hash #(
  parameter int unsigned KEY_BYTES = hsrl_pkg::DEF_KEY_BYTES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [2*hsrl_pkg::KEY_W-1:0]   key_i,
  output logic                           done_o,
  output logic [hsrl_pkg::HASH_W-1:0]    hash_o
);

  import hsrl_pkg::*;

  localparam logic [4:0] KEY_LEN  = 5'(KEY_BYTES);
  localparam logic [4:0] STEP_LEN = 5'(BYTES_PER_STEP);

  logic [2*KEY_W-1:0] key_q;
  logic [HASH_W-1:0]  h_q, h_d;
  logic [4:0]         left_q;
  logic               run_q, done_q;
  logic               last;

  // fold the next bytes, skipping those past the key length
  always_comb begin
    h_d = h_q;
    for (int j = 0; j < BYTES_PER_STEP; j++) begin
      if (5'(j) < left_q) begin
        h_d = (h_d << HASH_SHIFT) + h_d + {24'b0, key_q[j*8 +: 8]};
      end
    end
  end

  assign last = (left_q <= STEP_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      left_q <= '0;
    end else begin
      done_q <= run_q && last;
      if (start_i) begin
        run_q  <= 1'b1;
        left_q <= KEY_LEN;
      end else if (run_q) begin
        left_q <= left_q - STEP_LEN;
        if (last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q   <= HASH_SEED;
      key_q <= key_i;
    end else if (run_q) begin
      h_q   <= h_d;
      key_q <= key_q >> (8 * BYTES_PER_STEP);
    end
  end

  assign done_o = done_q;
  assign hash_o = h_q;

endmodule

### design/hsrl_slot_sel.sv
// bucket number = hash mod NUM_SLOTS by reciprocal multiply and one correction
// three register stages; depends on hsrl_pkg
module hsrl_slot_sel #(
  parameter int unsigned NUM_SLOTS = hsrl_pkg::DEF_NUM_SLOTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hsrl_pkg::HASH_W-1:0]  hash_i,
  output logic                         done_o,
  output logic [$clog2(NUM_SLOTS)-1:0] slot_o
);

  import hsrl_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  // floor(2^32 / n): quotient estimate is short by at most one
  localparam logic [HASH_W-1:0] RECIP = 32'((64'd1 << 32) / NUM_SLOTS);
  localparam logic [HASH_W-1:0] NSLOT = 32'(NUM_SLOTS);

  logic [2*HASH_W-1:0] prod;
  logic [HASH_W-1:0]   hash_q, quot_q, rem_q;
  logic [SLOT_W-1:0]   slot_q;
  logic                v1_q, v2_q, v3_q;

  assign prod = 64'(hash_i) * 64'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hash_q <= hash_i;
      quot_q <= prod[2*HASH_W-1:HASH_W];
    end
    if (v1_q) begin
      rem_q <= hash_q - 32'(quot_q * NSLOT);
    end
    if (v2_q) begin
      slot_q <= (rem_q >= NSLOT) ? SLOT_W'(rem_q - NSLOT) : SLOT_W'(rem_q);
    end
  end

  assign done_o = v3_q;
  assign slot_o = slot_q;

endmodule

### design/hashed_source_rate_limiter.sv
// top level of the per-source fixed window rate limiter
// depends on hsrl_pkg, hsrl_hash, hsrl_slot_sel, hsrl_ram
//
//   channel   handshake                 payload
//   request   start / busy              key_low_i, key_high_i, time_ms_i
//   result    result_valid_o (strobe)   reject_o, slot_index_o
//   config    cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one request at a time: a beat is taken when start is high and busy low,
// its result strobes once the hash, the bucket modulo and the bucket read
// are done, and busy drops in that same cycle, so the next beat can be
// taken then; a new request is not taken before the last one is through.
// the pace is set by the four-byte-per-cycle hash loop, the three-stage
// bucket modulo and the read then write of the bucket memory.
// after reset a clearing pass writes every bucket empty with busy high;
// config writes are taken throughout.
// the result is shown for one cycle and cannot be held off.
module hashed_source_rate_limiter #(
  parameter int unsigned NUM_SLOTS = hsrl_pkg::DEF_NUM_SLOTS,
  parameter int unsigned KEY_BYTES = hsrl_pkg::DEF_KEY_BYTES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request
  input  logic                               start,
  output logic                               busy,
  input  logic [hsrl_pkg::KEY_W-1:0]         key_low_i,
  input  logic [hsrl_pkg::KEY_W-1:0]         key_high_i,
  input  logic [hsrl_pkg::TIME_W-1:0]        time_ms_i,
  // result
  output logic                               result_valid_o,
  output logic                               reject_o,
  output logic [hsrl_pkg::SLOT_O_W-1:0]      slot_index_o,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [hsrl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hsrl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  import hsrl_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned WORD_W = $bits(bucket_t);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // control states
  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_WORK   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [SLOT_W-1:0] clr_addr_q;

  // config registers
  logic [CFG_DATA_W-1:0] rate_limit_q, window_q;

  // request capture
  logic              accept;
  logic [TIME_W-1:0] time_q;
  logic [SLOT_W-1:0] slot_q;

  // hash and bucket select
  logic              hash_done, slot_done;
  logic [HASH_W-1:0] hash;
  logic [SLOT_W-1:0] slot;

  // table memory
  logic              ram_we, ram_re;
  logic [SLOT_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_rdata;
  bucket_t           ram_wdata, cur, upd;

  // result
  logic                result_valid_q, reject_q, reject_d;
  logic [SLOT_O_W-1:0] slot_index_q;
  logic [SLOT_W+SLOT_O_W-1:0] slot_wide;

  // bucket update
  logic              hit, elapsed;
  logic [TIME_W-1:0] diff;
  logic [COUNT_W-1:0] cnt_base, cnt_new;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // config writes land at any time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_limit_q <= '0;
      window_q     <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RATE_LIMIT: rate_limit_q <= cfg_wdata_i;
        REG_WINDOW_MS:  window_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hsrl_hash #(
    .KEY_BYTES(KEY_BYTES)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .key_i  ({key_high_i, key_low_i}),
    .done_o (hash_done),
    .hash_o (hash)
  );

  hsrl_slot_sel #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_slot_sel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_done),
    .hash_i (hash),
    .done_o (slot_done),
    .slot_o (slot)
  );

  // bucket read is issued as soon as the bucket number is known
  assign ram_re = (state_q == ST_WORK) && slot_done;

  // modify: a miss takes the bucket over, a hit restarts the window when
  // the signed age is non-negative and at least window_ms, then counts up
  assign cur      = bucket_t'(ram_rdata);
  assign hit      = cur.valid && (cur.hash == hash);
  assign diff     = time_q - cur.start_ms;
  assign elapsed  = !diff[TIME_W-1] && (diff >= {16'b0, window_q});
  assign cnt_base = elapsed ? '0 : cur.count;
  assign cnt_new  = (cnt_base == COUNT_MAX) ? COUNT_MAX : cnt_base + COUNT_W'(1);

  always_comb begin
    upd.valid = 1'b1;
    upd.hash  = hash;
    if (hit) begin
      upd.count    = cnt_new;
      upd.start_ms = elapsed ? time_q : cur.start_ms;
      reject_d     = (cnt_new > rate_limit_q);
    end else begin
      upd.count    = COUNT_W'(1);
      upd.start_ms = time_q;
      reject_d     = 1'b0;
    end
    // limit of zero: pass everything, table untouched
    if (rate_limit_q == '0) begin
      reject_d = 1'b0;
    end
  end

  // write side: clearing sweep or bucket write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = upd;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      ST_UPDATE: begin
        ram_we = (rate_limit_q != '0);
      end
      default: ;
    endcase
  end

  hsrl_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(slot),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_addr_q == LAST_SLOT) state_d = ST_IDLE;
      ST_IDLE:   if (start) state_d = ST_WORK;
      ST_WORK:   if (slot_done) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_addr_q     <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= (state_q == ST_UPDATE);
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + SLOT_W'(1);
      end
    end
  end

  // slot index reports the low six bits of the bucket number
  assign slot_wide = {{SLOT_O_W{1'b0}}, slot_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      time_q <= time_ms_i;
    end
    if (ram_re) begin
      slot_q <= slot;
    end
    if (state_q == ST_UPDATE) begin
      reject_q     <= reject_d;
      slot_index_q <= slot_wide[SLOT_O_W-1:0];
    end
  end

  assign result_valid_o = result_valid_q;
  assign reject_o       = reject_q;
  assign slot_index_o   = slot_index_q;

endmodule
